// File: sv/lsv_pkg.sv
// Shared types and constants for the five-point Laplacian vorticity core.
package lsv_pkg;

   localparam int unsigned PSI_W      = 32;
   localparam int unsigned SCALE_W    = 24;
   localparam int unsigned GSIZE_W    = 7;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned LAP_W      = 35;
   localparam int unsigned LAP_LO_W   = 17;
   localparam int unsigned PP_LO_W    = LAP_LO_W + SCALE_W;
   localparam int unsigned PP_HI_W    = (LAP_W - LAP_LO_W) + SCALE_W + 1;
   localparam int unsigned PROD_W     = 60;
   localparam int unsigned FRAC_SHIFT = 12;
   localparam int unsigned GRID_MIN   = 3;

   localparam logic [GSIZE_W-1:0] GRID_SIZE_RESET = 7'd32;
   localparam logic [SCALE_W-1:0] INV_SPACING_RESET = 24'd4096;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 60'sd2048;

   localparam int unsigned CSR_IW = 1;
   localparam logic [CSR_IW-1:0] REG_GRID_SIZE   = 1'b0;
   localparam logic [CSR_IW-1:0] REG_INV_SPACING = 1'b1;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = 2;

   typedef struct packed {
      logic             emit1;
      logic             interior;
      logic             emit2;
      logic             last2;
      logic [POS_W-1:0] row1;
      logic [POS_W-1:0] row2;
      logic [POS_W-1:0] col;
   } lsv_meta_type;

   typedef struct packed {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [PSI_W-1:0] vort;
      logic                    last;
   } lsv_result_type;

endpackage

// File: sv/laplacian_stencil_vorticity_core.sv
// Streaming five-point Laplacian vorticity core with line buffers and result queue.
// Each item passes the pipeline stages and then the result queue to the rsp port.
// Throughput: one item per cycle while req_stall is low; results leave at one per
// cycle, so items of the last grid row (two results each) are limited by the rsp
// port and its 4-entry queue. Reset clears the raster counters, pipeline, queue and
// sets grid_size 32, inv_spacing_sq 4096; the line buffers are not cleared.
module laplacian_stencil_vorticity_core
   import lsv_pkg::*;
#(
   parameter int unsigned MAX_GRID = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [PSI_W-1:0]   req_psi_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POS_W-1:0]          rsp_out_row,
   output logic [POS_W-1:0]          rsp_out_col,
   output logic signed [PSI_W-1:0]   rsp_vorticity,
   output logic                      rsp_frame_last,
   input  logic                      csr_write_en,
   input  logic [CSR_IW-1:0]         csr_index,
   input  logic [SCALE_W-1:0]        csr_data
);

   localparam int unsigned CW = $clog2(MAX_GRID);
   localparam int unsigned NW = $clog2(MAX_GRID + 1);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_GRID);

   // configuration
   logic [GSIZE_W-1:0] grid_size_ff;
   logic [SCALE_W-1:0] inv_spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff   <= GRID_SIZE_RESET;
         inv_spacing_ff <= INV_SPACING_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_GRID_SIZE:   grid_size_ff   <= csr_data[GSIZE_W-1:0];
            REG_INV_SPACING: inv_spacing_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective grid size
   logic [31:0]   gs_wide;
   logic [NW-1:0] grid_n;

   always_comb begin
      gs_wide = 32'(grid_size_ff);
      if (gs_wide < 32'(GRID_MIN)) begin
         grid_n = NW'(GRID_MIN);
      end else if (gs_wide > 32'(MAX_GRID)) begin
         grid_n = MAX_N;
      end else begin
         grid_n = NW'(grid_size_ff);
      end
   end

   // queue room gates the whole pipeline
   logic [FIFO_AW:0] count_ff;
   logic             adv;

   assign adv       = count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
   assign req_stall = !adv;

   // stage 1: input register
   logic                    s1_valid_ff;
   logic signed [PSI_W-1:0] s1_psi_ff;

   // raster position of the item in stage 1
   logic [CW-1:0] col_ff, row_ff, col_in, row_in;
   logic [NW-1:0] col_eff, row_eff, col_inc, row_inc;
   logic [CW-1:0] mid_addr, right_addr;
   lsv_meta_type  s1_meta;

   always_comb begin
      col_eff = (NW'(col_ff) >= grid_n) ? '0 : NW'(col_ff);
      row_eff = (NW'(row_ff) >= grid_n) ? '0 : NW'(row_ff);
      col_inc = col_eff + NW'(1);
      row_inc = row_eff + NW'(1);
      if (col_inc == grid_n) begin
         col_in = '0;
         row_in = (row_inc == grid_n) ? '0 : CW'(row_inc);
      end else begin
         col_in = CW'(col_inc);
         row_in = CW'(row_eff);
      end
      mid_addr   = CW'(col_eff);
      right_addr = (col_inc == MAX_N) ? '0 : CW'(col_inc);
      s1_meta.emit1    = row_eff != '0;
      s1_meta.interior = (row_eff >= NW'(2)) && (col_eff != '0) && (col_inc != grid_n);
      s1_meta.emit2    = (row_eff != '0) && (row_inc == grid_n);
      s1_meta.last2    = col_inc == grid_n;
      s1_meta.row2     = POS_W'(row_eff);
      s1_meta.row1     = POS_W'(row_eff) - POS_W'(1);
      s1_meta.col      = POS_W'(col_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (s1_valid_ff && adv) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 2: line buffer data, stencil sum
   logic                    s2_valid_ff;
   logic signed [PSI_W-1:0] s2_psi_ff;
   logic [CW-1:0]           s2_addr_ff;
   lsv_meta_type            s2_meta_ff;
   logic signed [PSI_W-1:0] mid_rd_ff, right_rd_ff, up_rd_ff, left_held_ff;
   logic signed [PSI_W-1:0] prev_row_mem  [MAX_GRID];
   logic signed [PSI_W-1:0] prev2_row_mem [MAX_GRID];

   always_ff @(posedge clock) begin
      if (s2_valid_ff && adv) begin
         prev_row_mem[s2_addr_ff]  <= s2_psi_ff;
         prev2_row_mem[s2_addr_ff] <= mid_rd_ff;
      end
      if (adv) begin
         mid_rd_ff   <= prev_row_mem[mid_addr];
         right_rd_ff <= prev_row_mem[right_addr];
         up_rd_ff    <= prev2_row_mem[mid_addr];
      end
   end

   logic signed [LAP_W-1:0] nb_sum, neg_lap;

   always_comb begin
      nb_sum  = LAP_W'(left_held_ff) + LAP_W'(right_rd_ff) + LAP_W'(up_rd_ff)
              + LAP_W'(s2_psi_ff);
      neg_lap = (LAP_W'(mid_rd_ff) <<< 2) - nb_sum;
   end

   // stage 3: partial products
   logic                    s3_valid_ff;
   lsv_meta_type            s3_meta_ff;
   logic signed [LAP_W-1:0] s3_lap_ff;
   logic [PP_LO_W-1:0]      pp_lo;
   logic signed [PP_HI_W-1:0] pp_hi;

   always_comb begin
      pp_lo = PP_LO_W'(s3_lap_ff[LAP_LO_W-1:0]) * PP_LO_W'(inv_spacing_ff);
      pp_hi = PP_HI_W'($signed(s3_lap_ff[LAP_W-1:LAP_LO_W]))
            * $signed(PP_HI_W'(inv_spacing_ff));
   end

   // stage 4: full product
   logic                      s4_valid_ff;
   lsv_meta_type              s4_meta_ff;
   logic [PP_LO_W-1:0]        s4_lo_ff;
   logic signed [PP_HI_W-1:0] s4_hi_ff;
   logic signed [PROD_W-1:0]  prod;

   assign prod = (PROD_W'(s4_hi_ff) <<< LAP_LO_W) + $signed(PROD_W'(s4_lo_ff));

   // stage 5: round, saturate, queue
   logic                     s5_valid_ff;
   lsv_meta_type             s5_meta_ff;
   logic signed [PROD_W-1:0] s5_prod_ff;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PSI_W-1:0]  vort_sat;
   lsv_result_type           res_first, res_second;

   always_comb begin
      rounded = s5_prod_ff + ROUND_HALF;
      if (rounded[PROD_W-1:FRAC_SHIFT+PSI_W-1] == '0 ||
          rounded[PROD_W-1:FRAC_SHIFT+PSI_W-1] == '1) begin
         vort_sat = rounded[FRAC_SHIFT+PSI_W-1:FRAC_SHIFT];
      end else if (rounded[PROD_W-1]) begin
         vort_sat = {1'b1, {(PSI_W-1){1'b0}}};
      end else begin
         vort_sat = {1'b0, {(PSI_W-1){1'b1}}};
      end
      res_first.row   = s5_meta_ff.row1;
      res_first.col   = s5_meta_ff.col;
      res_first.vort  = s5_meta_ff.interior ? vort_sat : '0;
      res_first.last  = 1'b0;
      res_second.row  = s5_meta_ff.row2;
      res_second.col  = s5_meta_ff.col;
      res_second.vort = '0;
      res_second.last = s5_meta_ff.last2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_psi_ff  <= req_psi_sample;
         s2_psi_ff  <= s1_psi_ff;
         s2_addr_ff <= mid_addr;
         s2_meta_ff <= s1_meta;
         s3_meta_ff <= s2_meta_ff;
         s3_lap_ff  <= neg_lap;
         s4_meta_ff <= s3_meta_ff;
         s4_lo_ff   <= pp_lo;
         s4_hi_ff   <= pp_hi;
         s5_meta_ff <= s4_meta_ff;
         s5_prod_ff <= prod;
      end
      if (s2_valid_ff && adv) begin
         left_held_ff <= mid_rd_ff;
      end
   end

   // result queue
   lsv_result_type     fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_nx;
   logic               push_first, push_second, pop;
   logic [FIFO_AW-1:0] push_n;
   logic [FIFO_AW:0]   count_in;
   lsv_result_type     head;

   always_comb begin
      push_first  = s5_valid_ff && adv && s5_meta_ff.emit1;
      push_second = s5_valid_ff && adv && s5_meta_ff.emit2;
      push_n      = FIFO_AW'(push_first) + FIFO_AW'(push_second);
      wr_ptr_nx   = wr_ptr_ff + FIFO_AW'(1);
      pop         = rsp_valid && !rsp_stall;
      count_in    = count_ff + (FIFO_AW + 1)'(push_n) - (FIFO_AW + 1)'(pop);
      head        = fifo_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         fifo_mem[wr_ptr_ff] <= res_first;
      end
      if (push_second) begin
         fifo_mem[wr_ptr_nx] <= res_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_n;
         rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(pop);
         count_ff  <= count_in;
      end
   end

   assign rsp_valid      = count_ff != '0;
   assign rsp_out_row    = head.row;
   assign rsp_out_col    = head.col;
   assign rsp_vorticity  = head.vort;
   assign rsp_frame_last = head.last;

endmodule

// File: sim/laplacian_stencil_vorticity_core_tb.sv
// Self-checking testbench for the streaming five-point Laplacian vorticity core.
`timescale 1ns / 100ps

module laplacian_stencil_vorticity_core_tb;
   import lsv_pkg::*;

   localparam int unsigned GRID_MAX        = 64;
   localparam int unsigned ITEM_TARGET     = 1800;
   localparam int unsigned IDLE_PCT        = 30;
   localparam int unsigned QUIET_FROM      = 900;
   localparam int unsigned QUIET_TO        = 1200;
   localparam int unsigned PRESSURE_AT     = 400;
   localparam int unsigned PRESSURE_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES    = 10;
   localparam int unsigned BIG_PHASE       = 4;
   localparam longint      TIMEOUT_NS      = 1000000;
   localparam longint      VORT_MAX        = 64'sd2147483647;
   localparam longint      VORT_MIN        = -64'sd2147483648;

   localparam logic signed [PSI_W-1:0] PSI_LOW   = 32'sh8000_0000;
   localparam logic signed [PSI_W-1:0] PSI_HIGH  = 32'sh7FFF_FFFF;
   localparam logic [SCALE_W-1:0]      SCALE_TOP = '1;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [PSI_W-1:0] req_psi_sample;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [POS_W-1:0]        rsp_out_row;
   logic [POS_W-1:0]        rsp_out_col;
   logic signed [PSI_W-1:0] rsp_vorticity;
   logic                    rsp_frame_last;
   logic                    csr_write_en;
   logic [CSR_IW-1:0]       csr_index;
   logic [SCALE_W-1:0]      csr_data;

   int unsigned items_sent  = 0;
   int unsigned grid_writes = 0;
   int unsigned resizes     = 0;
   int unsigned largest_n   = 0;

   class vorticity_scoreboard;
      logic [GSIZE_W-1:0]      grid_reg;
      logic [SCALE_W-1:0]      scale_reg;
      logic signed [PSI_W-1:0] row_above [GRID_MAX];
      logic signed [PSI_W-1:0] row_two_up [GRID_MAX];
      logic signed [PSI_W-1:0] left_mid;
      int unsigned             col_at;
      int unsigned             row_at;
      lsv_result_type          expected_points[$];
      int unsigned             errors;
      int unsigned             checked;
      int unsigned             interior;
      int unsigned             saturated;

      function new();
         grid_reg  = GRID_SIZE_RESET;
         scale_reg = INV_SPACING_RESET;
         left_mid  = '0;
         col_at    = 0;
         row_at    = 0;
         errors    = 0;
         checked   = 0;
         interior  = 0;
         saturated = 0;
         foreach (row_above[i]) begin
            row_above[i]  = '0;
            row_two_up[i] = '0;
         end
      endfunction

      function void set_reg(logic [CSR_IW-1:0] idx, logic [SCALE_W-1:0] value);
         if (idx == REG_GRID_SIZE) begin
            grid_reg = value[GSIZE_W-1:0];
         end else begin
            scale_reg = value;
         end
      endfunction

      function int unsigned grid_points();
         if (grid_reg < GRID_MIN) return GRID_MIN;
         if (grid_reg > GRID_MAX) return GRID_MAX;
         return grid_reg;
      endfunction

      // raw counters, not wrapped against the current size
      function bit at_frame_start();
         return col_at == 0 && row_at == 0;
      endfunction

      function logic signed [PSI_W-1:0] vorticity_at(logic signed [PSI_W-1:0] west,
                                                     logic signed [PSI_W-1:0] east,
                                                     logic signed [PSI_W-1:0] north,
                                                     logic signed [PSI_W-1:0] south,
                                                     logic signed [PSI_W-1:0] centre);
         longint lap;
         longint prod;
         longint q;
         lap  = longint'(west) + longint'(east) + longint'(north) + longint'(south)
                - 4 * longint'(centre);
         prod = -(lap * longint'({1'b0, scale_reg}));
         q    = (prod + longint'(ROUND_HALF)) >>> FRAC_SHIFT;
         if (q > VORT_MAX) begin
            q = VORT_MAX;
            saturated++;
         end else if (q < VORT_MIN) begin
            q = VORT_MIN;
            saturated++;
         end
         return q[PSI_W-1:0];
      endfunction

      function void take_sample(logic signed [PSI_W-1:0] psi);
         int unsigned             n;
         int unsigned             r;
         int unsigned             c;
         logic signed [PSI_W-1:0] centre;
         lsv_result_type          pt;
         n = grid_points();
         if (col_at >= n) col_at = 0;
         if (row_at >= n) row_at = 0;
         r = row_at;
         c = col_at;
         centre = row_above[c];
         if (r >= 1) begin
            pt.row  = POS_W'(r - 1);
            pt.col  = POS_W'(c);
            pt.vort = '0;
            pt.last = 1'b0;
            if (r >= 2 && r + 1 <= n && c >= 1 && c + 2 <= n) begin
               pt.vort = vorticity_at(left_mid, row_above[c + 1], row_two_up[c], psi, centre);
               interior++;
            end
            expected_points.push_back(pt);
            // last row also closes out its own border row
            if (r + 1 == n) begin
               pt.row  = POS_W'(r);
               pt.vort = '0;
               pt.last = (c + 1 == n);
               expected_points.push_back(pt);
            end
         end
         row_two_up[c] = centre;
         row_above[c]  = psi;
         left_mid      = centre;
         col_at = c + 1;
         if (col_at >= n) begin
            col_at = 0;
            row_at = r + 1;
            if (row_at >= n) row_at = 0;
         end
      endfunction

      function void check_point(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                logic signed [PSI_W-1:0] vort, logic last);
         lsv_result_type want;
         if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected result row %0d col %0d vorticity %h",
                     $time, row, col, vort);
            return;
         end
         want = expected_points.pop_front();
         checked++;
         if (row !== want.row) begin
            errors++;
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, row);
         end
         if (col !== want.col) begin
            errors++;
            $display("%0t: out_col expected %0d actual %0d", $time, want.col, col);
         end
         if (vort !== want.vort) begin
            errors++;
            $display("%0t: vorticity at (%0d,%0d) expected %h actual %h",
                     $time, want.row, want.col, want.vort, vort);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: frame_last at (%0d,%0d) expected %b actual %b",
                     $time, want.row, want.col, want.last, last);
         end
      endfunction
   endclass

   vorticity_scoreboard sb;

   laplacian_stencil_vorticity_core #(
      .MAX_GRID(GRID_MAX)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_psi_sample (req_psi_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_vorticity  (rsp_vorticity),
      .rsp_frame_last (rsp_frame_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit quiet_window();
      return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
   endfunction

   function automatic logic signed [PSI_W-1:0] pick_psi();
      int unsigned             sel;
      logic signed [PSI_W-1:0] psi;
      sel = $urandom_range(99);
      if (sel < 8) begin
         case ($urandom_range(3))
            0:       psi = PSI_LOW;
            1:       psi = PSI_HIGH;
            2:       psi = '0;
            default: psi = '1;
         endcase
      end else if (sel < 55) begin
         psi = $urandom_range(0, 1048575);
         psi = psi - 524288;
      end else begin
         psi = $urandom;
      end
      return psi;
   endfunction

   task automatic send_psi(input logic signed [PSI_W-1:0] psi);
      if (!quiet_window()) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_psi_sample <= psi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_sample(psi);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= SCALE_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, SCALE_W'(value));
      if (idx == REG_GRID_SIZE) begin
         grid_writes++;
         if (sb.grid_points() > largest_n) largest_n = sb.grid_points();
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : rsp_driver
      int unsigned hold_left;
      bit          pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet_window() && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_point(rsp_out_row, rsp_out_col, rsp_vorticity, rsp_frame_last);
      end
   end

   initial begin : stimulus
      int unsigned        n;
      int unsigned        frames;
      int unsigned        partial;
      int unsigned        grid_pick;
      int unsigned        sel;
      int unsigned        phase_no;
      logic [SCALE_W-1:0] scale_pick;

      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_psi_sample = '0;
      csr_write_en   = 1'b0;
      csr_index      = REG_GRID_SIZE;
      csr_data       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 grid, full scale: positive saturation at the one interior point
      write_reg(REG_INV_SPACING, SCALE_TOP);
      write_reg(REG_GRID_SIZE, 0);
      for (int k = 0; k < 9; k++) send_psi((k == 4) ? PSI_HIGH : PSI_LOW);
      wait_drain();

      // smallest scale, Laplacian of +0.5 LSB: rounding tie
      write_reg(REG_INV_SPACING, 1);
      write_reg(REG_GRID_SIZE, 2);
      for (int k = 0; k < 9; k++) send_psi((k % 2 == 1) ? 32'sd512 : 32'sd0);
      wait_drain();

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_drain();
         case ($urandom_range(5))
            0:       scale_pick = '0;
            1:       scale_pick = SCALE_TOP;
            2:       scale_pick = INV_SPACING_RESET;
            3:       scale_pick = $urandom_range(1, 8192);
            default: scale_pick = $urandom;
         endcase
         if ($urandom_range(3) != 0) write_reg(REG_INV_SPACING, scale_pick);

         sel = $urandom_range(99);
         if (phase_no == BIG_PHASE) begin
            grid_pick = ($urandom_range(1) != 0) ? GRID_MAX : $urandom_range(GRID_MAX + 1, 127);
         end else if (sel < 10) begin
            grid_pick = $urandom_range(0, GRID_MIN - 1);
         end else if (sel < 15) begin
            grid_pick = GRID_MIN;
         end else if (sel < 85) begin
            grid_pick = $urandom_range(4, 10);
         end else begin
            grid_pick = $urandom_range(11, 20);
         end
         write_reg(REG_GRID_SIZE, grid_pick);
         n = sb.grid_points();

         frames = (phase_no == BIG_PHASE) ? 0 : $urandom_range(1, 3);
         repeat (frames * n * n) send_psi(pick_psi());

         // shrink mid-frame once two full rows are in the line buffers
         if (n >= 4 && (phase_no == BIG_PHASE || $urandom_range(2) == 0)) begin
            if (phase_no == BIG_PHASE) begin
               partial = 2 * n + $urandom_range(0, 3 * n);
            end else begin
               partial = 2 * n + $urandom_range(0, n * n - 2 * n - 1);
            end
            repeat (partial) send_psi(pick_psi());
            wait_drain();
            if (phase_no == BIG_PHASE) begin
               write_reg(REG_GRID_SIZE, $urandom_range(0, 12));
            end else begin
               write_reg(REG_GRID_SIZE, $urandom_range(0, n - 1));
            end
            resizes++;
            while (!sb.at_frame_start()) send_psi(pick_psi());
         end
         phase_no++;
      end

      wait_drain();
      $display("summary: %0d samples, %0d results checked, %0d interior, %0d saturated",
               items_sent, sb.checked, sb.interior, sb.saturated);
      $display("summary: %0d grid size writes, %0d mid-frame shrinks, largest grid %0d",
               grid_writes, resizes, largest_n);
      if (sb.errors == 0 && sb.expected_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
